// File: hdl/catmull_rom_spline_evaluator_top_macros.svh
// Assertion macros shared by the spline evaluator checker.
// No dependencies.
`ifndef CATMULL_ROM_SPLINE_EVALUATOR_TOP_MACROS_SVH
`define CATMULL_ROM_SPLINE_EVALUATOR_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define CRS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: hdl/crs_pkg.sv
// Shared types and constants for the Catmull-Rom spline evaluator.
// No dependencies.
package crs_pkg;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NEG_T = 2'd1;
  localparam logic [1:0] ST_FEW_PTS = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL = 1'b1;
  localparam logic CFG_LOOP_MODE = 1'b0;
  localparam logic CFG_POINT_COUNT = 1'b1;
  // control point table depth, matches the 8-bit point index
  localparam int MaxPoints = 256;
  // horner accumulator width (enough for all intermediates)
  localparam int AccW = 40;

  typedef struct packed {
    logic        valid;
    logic        is_eval;
    logic [1:0]  status;
    logic [16:0] frac;
  } ctl_t;
endpackage

// File: hdl/crs_horner_step.sv
// One registered Horner step: acc_out = coef + round(acc_in * frac / 2^16).
// Depends on crs_pkg.
module crs_horner_step (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [crs_pkg::AccW-1:0]   acc_in,
  input  logic signed [crs_pkg::AccW-1:0]   coef,
  input  logic        [16:0]                frac,
  output logic signed [crs_pkg::AccW-1:0]   acc_out
);
  logic signed [crs_pkg::AccW+17:0] prod;
  logic signed [crs_pkg::AccW+17:0] rnd;

  // multiply by nonnegative fraction, round half up, arithmetic shift = floor
  always_comb begin
    prod = acc_in * $signed({1'b0, frac});
    rnd  = (prod + (crs_pkg::AccW+18)'(32768)) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (en) acc_out <= coef + rnd[crs_pkg::AccW-1:0];
  end
endmodule

// File: hdl/crs_cubic.sv
// Cubic evaluation lane for one coordinate: coefficients, three Horner
// steps and the final halve-and-saturate. Depends on crs_pkg, crs_horner_step.
module crs_cubic (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] p0,
  input  logic signed [31:0] p1,
  input  logic signed [31:0] p2,
  input  logic signed [31:0] p3,
  input  logic        [16:0] frac_c,
  input  logic        [16:0] frac_1,
  input  logic        [16:0] frac_2,
  output logic signed [31:0] result
);
  localparam int W = crs_pkg::AccW;
  logic signed [W-1:0] e0, e1, e2, e3;
  logic signed [W-1:0] ca, cb, cc, cd;
  logic signed [W-1:0] a1, b1, a2, b2, a3;
  logic signed [W-1:0] acc1, acc2, acc3;
  logic signed [W-1:0] half;

  assign e0 = W'(p0);
  assign e1 = W'(p1);
  assign e2 = W'(p2);
  assign e3 = W'(p3);

  // coefficient stage
  always_ff @(posedge clk) begin
    if (en) begin
      ca <= e1 <<< 1;
      cb <= e2 - e0;
      cc <= (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
      cd <= e1 + (e1 <<< 1) - e0 - (e2 + (e2 <<< 1)) + e3;
    end
  end
  // delay the coefficients that are used later
  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= ca;
      b1 <= cb;
      a2 <= a1;
    end
  end
  assign b2 = b1;
  assign a3 = a2;

  crs_horner_step u_h1 (.clk, .en, .acc_in(cd), .coef(cc), .frac(frac_c), .acc_out(acc1));
  crs_horner_step u_h2 (.clk, .en, .acc_in(acc1), .coef(b2), .frac(frac_1), .acc_out(acc2));
  crs_horner_step u_h3 (.clk, .en, .acc_in(acc2), .coef(a3), .frac(frac_2), .acc_out(acc3));

  // floor((acc+1)/2) and clamp
  always_comb begin
    half = (acc3 + W'(1)) >>> 1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (half > W'(32'sh7fffffff)) result <= 32'sh7fffffff;
      else if (half < -W'(33'sh080000000)) result <= 32'sh80000000;
      else result <= half[31:0];
    end
  end
endmodule

// File: hdl/catmull_rom_spline_evaluator_top.sv
// Catmull-Rom spline evaluator: control point table, segment addressing and
// a pipelined Horner cubic. Depends on crs_pkg, crs_cubic, crs_horner_step.
//
// Usage:
//   s_axis carries one item per handshake. op=0 writes point (x,y) at
//   point_index; op=1 evaluates the spline at param_t. Every item returns
//   exactly one result on m_axis: curve_x, curve_y and status.
//   Configuration: cfg_we/cfg_index/cfg_data; index 0 loop_mode,
//   index 1 point_count. Write only while the block is idle.
//   Throughput: one item per cycle unless the receiver stalls; the pipeline
//   is a single stall-enabled chain (two table copies, each with two
//   registered read ports, in the read stage; point writes land in that same
//   stage so every evaluation sees exactly the writes ahead of it; one
//   multiplier per Horner step per coordinate).
//   Reset clears all valid bits and the configuration registers; table
//   contents are undefined until written.
//   When the receiver stalls, the whole pipeline holds; s_axis_tready is low
//   only while the output stage is full and not taken, so nothing is lost.
module catmull_rom_spline_evaluator_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // op[0], point_index[8:1], point_x[40:9], point_y[72:41], param_t[98:73], zero pad
  input  logic [103:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // curve_x[31:0], curve_y[63:32], status[65:64], zero pad
  output logic [71:0]   m_axis_tdata,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [8:0]    cfg_data
);
  localparam int IW = $clog2(crs_pkg::MaxPoints);
  localparam int NS = 8;

  logic        loop_mode;
  logic [8:0]  point_count;
  logic        en;
  logic        in_op;
  logic [7:0]  in_idx;
  logic [31:0] in_x, in_y;
  logic signed [25:0] in_t;

  assign in_op  = s_axis_tdata[0];
  assign in_idx = s_axis_tdata[8:1];
  assign in_x   = s_axis_tdata[40:9];
  assign in_y   = s_axis_tdata[72:41];
  assign in_t   = s_axis_tdata[98:73];

  // global stall: advance unless output holds an untaken item
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_mode   <= 1'b0;
      point_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crs_pkg::CFG_LOOP_MODE:   loop_mode <= cfg_data[0];
        crs_pkg::CFG_POINT_COUNT: point_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: check t, pick segment and fraction
  logic [12:0] n_eff;
  logic [12:0] tmax;
  logic [9:0]  seg_raw;
  logic [1:0]  st_a;
  crs_pkg::ctl_t c1;
  logic [12:0] seg1, n1;
  logic        lp1;
  // point write data rides with the item down to the read stage
  logic [63:0]   wd1, wd2;
  logic [IW-1:0] wi1, wi2;

  always_comb begin
    n_eff = (13'(point_count) > 13'(crs_pkg::MaxPoints)) ? 13'(crs_pkg::MaxPoints)
                                                          : 13'(point_count);
    tmax  = loop_mode ? n_eff : n_eff - 13'd3;
    seg_raw = in_t[25:16];
    priority if (in_t[25]) st_a = crs_pkg::ST_NEG_T;
    else if (n_eff < 13'd4) st_a = crs_pkg::ST_FEW_PTS;
    else if ({4'd0, in_t[24:0]} > {tmax, 16'd0}) st_a = crs_pkg::ST_RANGE;
    else st_a = crs_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) c1.valid <= 1'b0;
    else if (en) c1.valid <= s_axis_tvalid;
    if (en) begin
      c1.is_eval <= in_op == crs_pkg::OP_EVAL;
      c1.status  <= (in_op == crs_pkg::OP_EVAL) ? st_a : crs_pkg::ST_OK;
      if (13'(seg_raw) >= tmax) begin
        seg1    <= tmax - 13'd1;
        c1.frac <= 17'h10000;
      end else begin
        seg1    <= 13'(seg_raw);
        c1.frac <= {1'b0, in_t[15:0]};
      end
      n1  <= n_eff;
      lp1 <= loop_mode;
      wd1 <= {in_y, in_x};
      wi1 <= in_idx[IW-1:0];
    end
  end

  // stage 2: neighbor indices
  crs_pkg::ctl_t c2;
  logic [12:0] i0, i1, i2, i3, s1, s2;
  always_comb begin
    s1 = seg1 + 13'd1;
    s2 = seg1 + 13'd2;
    if (lp1) begin
      i0 = (seg1 == 13'd0) ? n1 - 13'd1 : seg1 - 13'd1;
      i1 = seg1;
      i2 = (s1 >= n1) ? s1 - n1 : s1;
      i3 = (s2 >= n1) ? s2 - n1 : s2;
    end else begin
      i0 = seg1; i1 = s1; i2 = s2; i3 = seg1 + 13'd3;
    end
  end
  logic [IW-1:0] a0, a1, a2, a3;
  always_ff @(posedge clk) begin
    if (rst) c2.valid <= 1'b0;
    else if (en) c2.valid <= c1.valid;
    if (en) begin
      c2.is_eval <= c1.is_eval;
      c2.frac    <= c1.frac;
      c2.status  <= (c1.status == crs_pkg::ST_OK && c1.is_eval &&
                     (32'(i3) >= crs_pkg::MaxPoints || 32'(i2) >= crs_pkg::MaxPoints))
                    ? crs_pkg::ST_RANGE : c1.status;
      a0 <= i0[IW-1:0]; a1 <= i1[IW-1:0]; a2 <= i2[IW-1:0]; a3 <= i3[IW-1:0];
      wd2 <= wd1;
      wi2 <= wi1;
    end
  end

  // table: two identical copies, written in the read stage in item order
  logic [63:0] tbl_a [crs_pkg::MaxPoints];
  logic [63:0] tbl_b [crs_pkg::MaxPoints];
  always_ff @(posedge clk) begin
    if (en && c2.valid && !c2.is_eval) begin
      tbl_a[wi2] <= wd2;
      tbl_b[wi2] <= wd2;
    end
  end

  // stage 3: registered table reads, two per copy
  crs_pkg::ctl_t c3;
  logic [63:0] q0, q1, q2, q3;
  always_ff @(posedge clk) begin
    if (rst) c3.valid <= 1'b0;
    else if (en) c3.valid <= c2.valid;
    if (en) begin
      c3.is_eval <= c2.is_eval;
      c3.frac    <= c2.frac;
      c3.status  <= c2.status;
      q0 <= tbl_a[a0]; q1 <= tbl_a[a1]; q2 <= tbl_b[a2]; q3 <= tbl_b[a3];
    end
  end

  // stages 4..8: control travels beside the cubic lanes
  crs_pkg::ctl_t cp [4:NS];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 4; k <= NS; k++) cp[k].valid <= 1'b0;
    end else if (en) begin
      cp[4] <= c3;
      for (int k = 5; k <= NS; k++) cp[k] <= cp[k-1];
    end
  end

  logic signed [31:0] rx, ry;
  crs_cubic u_cx (.clk, .en,
    .p0(q0[31:0]), .p1(q1[31:0]), .p2(q2[31:0]), .p3(q3[31:0]),
    .frac_c(cp[4].frac), .frac_1(cp[5].frac), .frac_2(cp[6].frac),
    .result(rx));
  crs_cubic u_cy (.clk, .en,
    .p0(q0[63:32]), .p1(q1[63:32]), .p2(q2[63:32]), .p3(q3[63:32]),
    .frac_c(cp[4].frac), .frac_1(cp[5].frac), .frac_2(cp[6].frac),
    .result(ry));

  // output: zero unless an ok evaluation
  logic ok;
  assign ok = cp[NS].is_eval && cp[NS].status == crs_pkg::ST_OK;
  assign m_axis_tvalid = cp[NS].valid;
  assign m_axis_tdata  = {6'd0, cp[NS].status, ok ? ry : 32'd0, ok ? rx : 32'd0};
endmodule

// File: hdl/crs_checker.sv
// Port-level checker for the spline evaluator, bound to the top level.
// Depends on crs_pkg and the macros header.
`include "catmull_rom_spline_evaluator_top_macros.svh"
module crs_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [71:0]  m_axis_tdata
);
  `CRS_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed under stall")
  `CRS_ASSERT_IMPL(a_err_zero, clk, rst, m_axis_tvalid && m_axis_tdata[65:64] != crs_pkg::ST_OK, m_axis_tdata[63:0] == 64'd0, "error item with nonzero point")
  `CRS_ASSERT_IMPL(a_ready, clk, rst, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input blocked with free output")
  `CRS_ASSERT_IMPL(a_pad, clk, rst, m_axis_tvalid, m_axis_tdata[71:66] == 6'd0, "pad bits set")
endmodule

bind catmull_rom_spline_evaluator_top crs_checker u_crs_checker (.*);
